[rtl/core/sha1mh_pkg.sv]
package sha1mh_pkg;

    localparam int unsigned NUM_WORDS = 5;
    localparam int unsigned NUM_ROUNDS = 80;

    localparam logic [NUM_WORDS-1:0][31:0] H_INIT = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    localparam logic [31:0] K_CH   = 32'h5A827999;
    localparam logic [31:0] K_PAR1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_MAJ  = 32'h8F1BBCDC;
    localparam logic [31:0] K_PAR2 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    // byte source for the block shift line
    localparam logic [1:0] SEL_MSG  = 2'd0;
    localparam logic [1:0] SEL_PAD  = 2'd1;
    localparam logic [1:0] SEL_ZERO = 2'd2;
    localparam logic [1:0] SEL_LEN  = 2'd3;

    // round function group
    localparam logic [1:0] GRP_CH   = 2'd0;
    localparam logic [1:0] GRP_PAR1 = 2'd1;
    localparam logic [1:0] GRP_MAJ  = 2'd2;
    localparam logic [1:0] GRP_PAR2 = 2'd3;

    localparam logic [2:0] LAST_IDX = 3'd4;

    typedef struct packed {
        logic       shift;
        logic [1:0] sel;
        logic       count;
        logic       load;
        logic       round;
        logic [1:0] grp;
        logic       add;
        logic       clear;
        logic [2:0] oidx;
    } cmd_t;

    typedef struct packed {
        logic [5:0] pos;
    } stat_t;

endpackage

[rtl/core/sha1_message_hasher_core.sv]
// one message byte per cycle while idle; a full 64-byte block then goes through load,
// 80 rounds on one round unit and the chain add, with the input stalled
// end of message: one cycle per padding byte until the block is full, one or two
// compressions, then five digest words at one per cycle when not stalled
// reset: chain words to their initial values, bit count and controller cleared
module sha1_message_hasher_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        msg_valid,
    output logic        msg_stall,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        end_of_message,
    output logic        digest_valid,
    input  logic        digest_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

    sha1mh_pkg::cmd_t  cmd;
    sha1mh_pkg::stat_t stat;

    sha1mh_ctrl u_ctrl
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .msg_valid      (msg_valid),
        .msg_stall      (msg_stall),
        .byte_present   (byte_present),
        .end_of_message (end_of_message),
        .digest_valid   (digest_valid),
        .digest_stall   (digest_stall),
        .stat           (stat),
        .cmd            (cmd)
    );

    sha1mh_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .data_byte   (data_byte),
        .digest_word (digest_word)
    );

    assign word_index = cmd.oidx;
    assign last_word  = (cmd.oidx == sha1mh_pkg::LAST_IDX);

endmodule

[rtl/core/sha1mh_datapath.sv]
module sha1mh_datapath
(
    input  logic                clk,
    input  logic                rst_n,
    input  sha1mh_pkg::cmd_t    cmd,
    output sha1mh_pkg::stat_t   stat,
    input  logic [7:0]          data_byte,
    output logic [31:0]         digest_word
);

    logic [511:0]                               blk_reg;
    logic [sha1mh_pkg::NUM_WORDS-1:0][31:0]     h_reg;
    logic [sha1mh_pkg::NUM_WORDS-1:0][31:0]     work_reg;
    logic [63:0]                                cnt_reg;
    logic [5:0]                                 pos_reg;

    logic [7:0][7:0] cnt_bytes;
    logic [7:0]      len_byte;
    logic [7:0]      in_byte;
    logic [31:0]     w0;
    logic [31:0]     w2;
    logic [31:0]     w8;
    logic [31:0]     w13;
    logic [31:0]     w_mix;
    logic [31:0]     w_new;
    logic [31:0]     f_val;
    logic [31:0]     k_val;
    logic [31:0]     tmp;
    logic [31:0]     wb;
    logic [31:0]     wc;
    logic [31:0]     wd;

    assign cnt_bytes = cnt_reg;
    assign len_byte  = cnt_bytes[~pos_reg[2:0]];
    assign stat.pos  = pos_reg;

    always_comb
    begin
        case (cmd.sel)
            sha1mh_pkg::SEL_MSG:  in_byte = data_byte;
            sha1mh_pkg::SEL_PAD:  in_byte = sha1mh_pkg::PAD_BYTE;
            sha1mh_pkg::SEL_LEN:  in_byte = len_byte;
            default:              in_byte = 8'h00;
        endcase
    end

    // rolling schedule window, current word on top
    assign w0    = blk_reg[511:480];
    assign w2    = blk_reg[447:416];
    assign w8    = blk_reg[255:224];
    assign w13   = blk_reg[95:64];
    assign w_mix = w13 ^ w8 ^ w2 ^ w0;
    assign w_new = {w_mix[30:0], w_mix[31]};

    assign wb = work_reg[1];
    assign wc = work_reg[2];
    assign wd = work_reg[3];

    always_comb
    begin
        case (cmd.grp)
            sha1mh_pkg::GRP_CH:
            begin
                f_val = (wb & wc) | (~wb & wd);
                k_val = sha1mh_pkg::K_CH;
            end
            sha1mh_pkg::GRP_PAR1:
            begin
                f_val = wb ^ wc ^ wd;
                k_val = sha1mh_pkg::K_PAR1;
            end
            sha1mh_pkg::GRP_MAJ:
            begin
                f_val = (wb & wc) | (wb & wd) | (wc & wd);
                k_val = sha1mh_pkg::K_MAJ;
            end
            default:
            begin
                f_val = wb ^ wc ^ wd;
                k_val = sha1mh_pkg::K_PAR2;
            end
        endcase
    end

    assign tmp = {work_reg[0][26:0], work_reg[0][31:27]} + f_val + work_reg[4] + k_val + w0;

    always_ff @(posedge clk)
    begin
        if (cmd.shift)
        begin
            blk_reg <= {blk_reg[503:0], in_byte};
        end
        else if (cmd.round)
        begin
            blk_reg <= {blk_reg[479:0], w_new};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            work_reg <= h_reg;
        end
        else if (cmd.round)
        begin
            work_reg[4] <= wd;
            work_reg[3] <= wc;
            work_reg[2] <= {wb[1:0], wb[31:2]};
            work_reg[1] <= work_reg[0];
            work_reg[0] <= tmp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_reg   <= sha1mh_pkg::H_INIT;
            cnt_reg <= 64'd0;
            pos_reg <= 6'd0;
        end
        else
        begin
            if (cmd.clear)
            begin
                h_reg   <= sha1mh_pkg::H_INIT;
                cnt_reg <= 64'd0;
                pos_reg <= 6'd0;
            end
            else
            begin
                if (cmd.add)
                begin
                    for (int i = 0; i < sha1mh_pkg::NUM_WORDS; i++)
                    begin
                        h_reg[i] <= h_reg[i] + work_reg[i];
                    end
                end
                if (cmd.shift)
                begin
                    pos_reg <= pos_reg + 6'd1;
                end
                if (cmd.count)
                begin
                    cnt_reg <= cnt_reg + 64'd8;
                end
            end
        end
    end

    always_comb
    begin
        case (cmd.oidx)
            3'd0:    digest_word = h_reg[0];
            3'd1:    digest_word = h_reg[1];
            3'd2:    digest_word = h_reg[2];
            3'd3:    digest_word = h_reg[3];
            default: digest_word = h_reg[4];
        endcase
    end

endmodule

[rtl/core/sha1mh_ctrl.sv]
module sha1mh_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                msg_valid,
    output logic                msg_stall,
    input  logic                byte_present,
    input  logic                end_of_message,
    output logic                digest_valid,
    input  logic                digest_stall,
    input  sha1mh_pkg::stat_t   stat,
    output sha1mh_pkg::cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOAD  = 3'd1;
    localparam logic [2:0] ST_ROUND = 3'd2;
    localparam logic [2:0] ST_ADD   = 3'd3;
    localparam logic [2:0] ST_PAD   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    localparam logic [6:0] LAST_ROUND = 7'(sha1mh_pkg::NUM_ROUNDS - 1);

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [6:0] rnd_reg;
    logic [6:0] rnd_next;
    logic       pad_reg;
    logic       pad_next;
    logic       first_reg;
    logic       first_next;
    logic       extra_reg;
    logic       extra_next;
    logic       last_reg;
    logic       last_next;
    logic [2:0] oidx_reg;
    logic [2:0] oidx_next;

    logic       pos_full;
    logic       pos_tail;

    assign pos_full     = (stat.pos == 6'd63);
    assign pos_tail     = (stat.pos >= 6'd56);
    assign msg_stall    = (state_reg != ST_IDLE);
    assign digest_valid = (state_reg == ST_OUT);

    always_comb
    begin
        state_next = state_reg;
        rnd_next   = rnd_reg;
        pad_next   = pad_reg;
        first_next = first_reg;
        extra_next = extra_reg;
        last_next  = last_reg;
        oidx_next  = oidx_reg;
        cmd        = '0;
        cmd.oidx   = oidx_reg;

        if (rnd_reg < 7'd20)
        begin
            cmd.grp = sha1mh_pkg::GRP_CH;
        end
        else if (rnd_reg < 7'd40)
        begin
            cmd.grp = sha1mh_pkg::GRP_PAR1;
        end
        else if (rnd_reg < 7'd60)
        begin
            cmd.grp = sha1mh_pkg::GRP_MAJ;
        end
        else
        begin
            cmd.grp = sha1mh_pkg::GRP_PAR2;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (msg_valid)
                begin
                    cmd.sel    = sha1mh_pkg::SEL_MSG;
                    cmd.shift  = byte_present;
                    cmd.count  = byte_present;
                    pad_next   = end_of_message;
                    first_next = end_of_message;
                    last_next  = 1'b0;
                    if (byte_present && pos_full)
                    begin
                        state_next = ST_LOAD;
                    end
                    else if (end_of_message)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                cmd.shift  = 1'b1;
                first_next = 1'b0;
                if (first_reg)
                begin
                    cmd.sel = sha1mh_pkg::SEL_PAD;
                    if (pos_tail)
                    begin
                        extra_next = 1'b1;
                    end
                end
                else if (pos_tail && !extra_reg)
                begin
                    cmd.sel = sha1mh_pkg::SEL_LEN;
                end
                else
                begin
                    cmd.sel = sha1mh_pkg::SEL_ZERO;
                end
                if (pos_full)
                begin
                    state_next = ST_LOAD;
                    last_next  = !(extra_reg || first_reg);
                end
            end
            ST_LOAD:
            begin
                cmd.load   = 1'b1;
                rnd_next   = 7'd0;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                cmd.round = 1'b1;
                if (rnd_reg == LAST_ROUND)
                begin
                    rnd_next   = 7'd0;
                    state_next = ST_ADD;
                end
                else
                begin
                    rnd_next = rnd_reg + 7'd1;
                end
            end
            ST_ADD:
            begin
                cmd.add    = 1'b1;
                extra_next = 1'b0;
                oidx_next  = 3'd0;
                if (last_reg)
                begin
                    state_next = ST_OUT;
                end
                else if (pad_reg)
                begin
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT:
            begin
                if (!digest_stall)
                begin
                    if (oidx_reg == sha1mh_pkg::LAST_IDX)
                    begin
                        cmd.clear  = 1'b1;
                        pad_next   = 1'b0;
                        last_next  = 1'b0;
                        oidx_next  = 3'd0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        oidx_next = oidx_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rnd_reg   <= 7'd0;
            pad_reg   <= 1'b0;
            first_reg <= 1'b0;
            extra_reg <= 1'b0;
            last_reg  <= 1'b0;
            oidx_reg  <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
            pad_reg   <= pad_next;
            first_reg <= first_next;
            extra_reg <= extra_next;
            last_reg  <= last_next;
            oidx_reg  <= oidx_next;
        end
    end

    a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rnd_reg <= LAST_ROUND)
        else $error("round counter out of range");

    a_round_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (rnd_reg != 7'd0) |-> (state_reg == ST_ROUND))
        else $error("round counter running outside compression");

    a_extra_pad: assert property (@(posedge clk) disable iff (!rst_n)
        extra_reg |-> pad_reg)
        else $error("extra block flag without padding");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(digest_valid && !msg_stall))
        else $error("input taken while digest pending");

    a_out_done: assert property (@(posedge clk) disable iff (!rst_n)
        (digest_valid && !digest_stall && oidx_reg == sha1mh_pkg::LAST_IDX)
        |=> (!digest_valid && !msg_stall))
        else $error("digest did not close after last word");

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps

class sha1_digest_ledger;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } digest_entry_t;

    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hEFCDAB89;
    localparam logic [31:0] IV2 = 32'h98BADCFE;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] IV4 = 32'hC3D2E1F0;
    localparam logic [31:0] K_ROUND0 = 32'h5A827999;
    localparam logic [31:0] K_ROUND1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_ROUND2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_ROUND3 = 32'hCA62C1D6;
    localparam logic [7:0]  PAD_MARK = 8'h80;
    localparam int unsigned LAST_POS = 4;

    logic [31:0]   chain [5];
    logic [31:0]   sched [16];
    logic [63:0]   bit_count;
    digest_entry_t pending_digest [$];
    int unsigned   failures;

    function new();
        restart_chain();
        foreach (sched[i]) sched[i] = '0;
        failures = 0;
    endfunction

    function void restart_chain();
        chain[0] = IV0;
        chain[1] = IV1;
        chain[2] = IV2;
        chain[3] = IV3;
        chain[4] = IV4;
        bit_count = '0;
    endfunction

    function void place_byte(input int unsigned pos, input logic [7:0] b);
        int unsigned wi;
        int unsigned sh;
        wi = (pos >> 2) & 15;
        sh = (3 - (pos & 3)) * 8;
        if ((pos & 3) == 0)
            sched[wi] = {24'd0, b} << sh;
        else
            sched[wi] = sched[wi] | ({24'd0, b} << sh);
    endfunction

    function void compress_block();
        logic [31:0] a, b, c, d, e, f, k, w, t;
        int r;
        a = chain[0];
        b = chain[1];
        c = chain[2];
        d = chain[3];
        e = chain[4];
        for (r = 0; r < 80; r++)
        begin
            if (r >= 16)
            begin
                w = sched[(r - 3) & 15] ^ sched[(r - 8) & 15] ^ sched[(r - 14) & 15]
                    ^ sched[r & 15];
                sched[r & 15] = {w[30:0], w[31]};
            end
            w = sched[r & 15];
            if (r < 20)
            begin
                f = (b & c) | (~b & d);
                k = K_ROUND0;
            end
            else if (r < 40)
            begin
                f = b ^ c ^ d;
                k = K_ROUND1;
            end
            else if (r < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = K_ROUND2;
            end
            else
            begin
                f = b ^ c ^ d;
                k = K_ROUND3;
            end
            t = {a[26:0], a[31:27]} + f + e + k + w;
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t;
        end
        chain[0] = chain[0] + a;
        chain[1] = chain[1] + b;
        chain[2] = chain[2] + c;
        chain[3] = chain[3] + d;
        chain[4] = chain[4] + e;
    endfunction

    function void absorb_word(input logic [7:0] b, input logic present, input logic closing);
        int unsigned pos;
        int unsigned i;
        digest_entry_t entry;
        if (present)
        begin
            pos = {26'd0, bit_count[8:3]};
            place_byte(pos, b);
            bit_count = bit_count + 64'd8;
            if (pos == 63)
                compress_block();
        end
        if (!closing)
            return;
        pos = {26'd0, bit_count[8:3]};
        place_byte(pos, PAD_MARK);
        pos++;
        if (pos > 56)
        begin
            while (pos < 64)
            begin
                place_byte(pos, 8'h00);
                pos++;
            end
            compress_block();
            pos = 0;
        end
        while (pos < 56)
        begin
            place_byte(pos, 8'h00);
            pos++;
        end
        sched[14] = bit_count[63:32];
        sched[15] = bit_count[31:0];
        compress_block();
        for (i = 0; i < 5; i++)
        begin
            entry.word = chain[i];
            entry.idx = i[2:0];
            entry.last = (i == LAST_POS);
            pending_digest.push_back(entry);
        end
        restart_chain();
    endfunction

    task report(input string msg);
        $display("mismatch: %s", msg);
        failures++;
    endtask

    task check_digest_word(input logic [31:0] word, input logic [2:0] idx, input logic last);
        digest_entry_t want;
        if (pending_digest.size() == 0)
        begin
            report($sformatf("unexpected digest word %h index %0d", word, idx));
            return;
        end
        want = pending_digest.pop_front();
        if (word !== want.word)
            report($sformatf("digest word %h, want %h (index %0d)", word, want.word, want.idx));
        if (idx !== want.idx)
            report($sformatf("word index %0d, want %0d", idx, want.idx));
        if (last !== want.last)
            report($sformatf("last word flag %b, want %b (index %0d)", last, want.last,
                             want.idx));
    endtask

    function int unsigned pending_count();
        return pending_digest.size();
    endfunction

endclass

module testbench;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned IDLE_PCT = 36;
    localparam int unsigned DRAIN_CYCLES = 300;
    localparam int unsigned HOLD_CYCLES = 600;
    localparam int unsigned ITEM_TARGET = 270;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        msg_valid = 1'b0;
    logic        msg_stall;
    logic [7:0]  data_byte = 8'h00;
    logic        byte_present = 1'b0;
    logic        end_of_message = 1'b0;
    logic        digest_valid;
    logic        digest_stall = 1'b0;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    bit          sender_calm = 1'b1;
    bit          receiver_calm = 1'b1;
    bit          receiver_hold = 1'b0;
    int unsigned items_sent = 0;
    int unsigned cycle_count = 0;

    sha1_digest_ledger ledger = new();

    sha1_message_hasher_core dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .msg_valid      (msg_valid),
        .msg_stall      (msg_stall),
        .data_byte      (data_byte),
        .byte_present   (byte_present),
        .end_of_message (end_of_message),
        .digest_valid   (digest_valid),
        .digest_stall   (digest_stall),
        .digest_word    (digest_word),
        .word_index     (word_index),
        .last_word      (last_word)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && digest_valid === 1'b1 && digest_stall === 1'b0)
            ledger.check_digest_word(digest_word, word_index, last_word);
        if (receiver_hold)
            digest_stall <= 1'b1;
        else if (receiver_calm)
            digest_stall <= 1'b0;
        else
            digest_stall <= ($urandom_range(0, 99) < IDLE_PCT);
    end

    task automatic send_word(input logic [7:0] b, input logic present, input logic closing);
        while (!sender_calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            msg_valid <= 1'b0;
            @(posedge clk);
        end
        msg_valid <= 1'b1;
        data_byte <= b;
        byte_present <= present;
        end_of_message <= closing;
        @(posedge clk);
        while (msg_stall !== 1'b0)
            @(posedge clk);
        ledger.absorb_word(b, present, closing);
        items_sent++;
    endtask

    // bytes with random content; the end flag rides on the last byte or on a word of its own
    task automatic send_message(input int unsigned len);
        int unsigned i;
        logic tail_end;
        tail_end = (len != 0) && ($urandom_range(0, 1) == 1);
        for (i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_word(8'($urandom_range(0, 255)), 1'b1, tail_end && (i == len - 1));
        end
        if (!tail_end)
            send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    // mostly short messages, many right at the padding boundaries
    function automatic int unsigned pick_length();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 5)
            return $urandom_range(0, 8);
        if (sel < 8)
        begin
            case ($urandom_range(0, 7))
                0: return 55;
                1: return 56;
                2: return 57;
                3: return 63;
                4: return 64;
                5: return 65;
                6: return 119;
                default: return 120;
            endcase
        end
        return $urandom_range(0, 70);
    endfunction

    task automatic hold_receiver(input int unsigned cycles);
        receiver_hold = 1'b1;
        repeat (cycles) @(posedge clk);
        receiver_hold = 1'b0;
    endtask

    task automatic wait_drained();
        msg_valid <= 1'b0;
        @(posedge clk);
        while (ledger.pending_count() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int unsigned len;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: empty words, empty message, single extreme bytes, abc, split end
        send_word(8'hFF, 1'b0, 1'b0);
        send_word(8'h00, 1'b0, 1'b1);
        send_word(8'h00, 1'b1, 1'b1);
        send_word(8'hFF, 1'b1, 1'b1);
        send_word(8'h61, 1'b1, 1'b0);
        send_word(8'h00, 1'b0, 1'b0);
        send_word(8'h62, 1'b1, 1'b0);
        send_word(8'h63, 1'b1, 1'b1);
        send_word(8'h61, 1'b1, 1'b0);
        send_word(8'h62, 1'b1, 1'b0);
        send_word(8'hFF, 1'b0, 1'b1);
        send_word(8'hA5, 1'b0, 1'b1);
        send_word(8'h5A, 1'b0, 1'b1);

        // random, first with no idling at all
        repeat (3) send_message(pick_length());
        sender_calm = 1'b0;
        receiver_calm = 1'b0;
        repeat (2) send_message(pick_length());

        // receiver held off while words keep coming
        fork
            hold_receiver(HOLD_CYCLES);
        join_none
        send_message(5);
        send_message(70);
        send_message(3);
        wait_drained();

        while (items_sent < ITEM_TARGET)
        begin
            len = pick_length();
            if (len > ITEM_TARGET - items_sent)
                len = ITEM_TARGET - items_sent;
            send_message(len);
        end
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (ledger.failures == 0 && ledger.pending_count() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
